/* design/tqm_pkg.sv */
// shared types, codes and defaults of the timeout queue manager
package tqm_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  typedef enum logic [2:0] {
    FN_ADD_TIMEOUT  = 3'd0,
    FN_ADD_ANIMATOR = 3'd1,
    FN_REMOVE       = 3'd2,
    FN_UPDATE       = 3'd3,
    FN_TERMINATE    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_HALTED    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_TIMEOUT   = 2'd1,
    KIND_ANIM_DONE = 2'd2,
    KIND_ANIM_TICK = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_MIN,
    S_FIRE,
    S_TICK,
    S_DUE,
    S_OUT_RD,
    S_OUT_SHOW
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] delay;
    logic [15:0] target_id;
    logic [31:0] new_time;
  } cmd_t;

  // one stored result, next_due and last are added on the way out
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] new_id;
    logic [15:0] fired_id;
    logic [1:0]  fired_kind;
    logic [31:0] elapsed;
  } rec_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] new_id;
    logic [15:0] fired_id;
    logic [1:0]  fired_kind;
    logic [31:0] elapsed;
    logic [31:0] next_due;
    logic        last;
  } rsp_t;

endpackage

/* design/timeout_queue_manager.sv */
// timeout queue manager top level: entry table, scan sequencer and result streaming
//
// usage
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one command beat: add timeout,
//   add animator, remove by id, update time or terminate. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns one or more beats per command, the
//   final one flagged by rsp.last; every beat of a command carries the same
//   next_due, which is why all beats are held back until the command is done.
//   one command is in flight at a time: cmd_stall stays high from acceptance
//   until the last beat of that command has been taken.
//   every command makes one pass over the entry memory, one entry per cycle;
//   a remove adds one pass, an update adds one pass per fired entry and one
//   more for animator ticks when time moves forward; then each result beat is
//   read from the result buffer, then presented.
//   a stalled rsp beat simply holds; nothing else moves while it waits.
//   reset (rst, synchronous) empties the table, zeroes time and the id counter
//   and clears the terminated flag; no clearing pass is needed.
module timeout_queue_manager #(
  parameter int TABLE_DEPTH = tqm_pkg::TABLE_DEPTH_DEF,
  parameter int TIME_BITS   = tqm_pkg::TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  tqm_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  output tqm_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);

  localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  // one table entry as stored in the entry memory
  typedef struct packed {
    logic                 kind;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] due;
    logic [15:0]          ident;
  } entry_t;

  tqm_pkg::state_t state, state_next;

  // control state
  logic [TABLE_DEPTH-1:0] valid;
  logic [TIME_BITS-1:0]   cur;
  logic [15:0]            nid;
  logic [CW-1:0]          anim;
  logic                   halted;

  // scan sequencer
  logic [SW-1:0] idx;
  logic          issuing;
  logic          pend;
  logic [SW-1:0] pslot;

  // best (earliest) entry of the latest pass
  logic                 have;
  logic [SW-1:0]        bslot;
  logic [TIME_BITS-1:0] bdue;
  logic [15:0]          bid;
  logic                 bkind;
  logic [TIME_BITS-1:0] bstart;

  // command context
  logic                 fire_en;
  logic                 fwd;
  logic [TIME_BITS-1:0] limit;
  logic [TIME_BITS-1:0] newt;
  logic [15:0]          target;
  logic                 found;
  logic [CW-1:0]        wptr;
  logic [CW-1:0]        rptr;
  logic [31:0]          nd;

  // entry memory
  entry_t emem [TABLE_DEPTH];
  entry_t eq;
  logic   ewe;
  logic [SW-1:0] ewaddr;
  entry_t ewdata;

  // result buffer ports
  logic          rb_we;
  logic [SW-1:0] rb_waddr;
  tqm_pkg::rec_t rb_wdata;
  tqm_pkg::rec_t rb_q;

  logic                 accept;
  logic                 scanning;
  logic                 scan_done;
  logic                 start_scan;
  logic                 free_hit;
  logic [SW-1:0]        free_slot;
  logic                 fire_hit;
  logic                 better;
  logic                 tick_hit;
  logic                 rm_hit;
  logic                 is_last;
  logic [TIME_BITS-1:0] cmd_delay;
  logic [TIME_BITS-1:0] cmd_newt;
  logic [TIME_BITS:0]   add_sum;
  logic [TIME_BITS-1:0] add_due;

  assign accept    = cmd_valid && !cmd_stall;
  assign scanning  = (state == tqm_pkg::S_REMOVE) || (state == tqm_pkg::S_MIN) ||
                     (state == tqm_pkg::S_TICK);
  assign scan_done = scanning && !issuing && !pend;
  assign cmd_delay = TIME_BITS'(cmd.delay);
  assign cmd_newt  = TIME_BITS'(cmd.new_time);
  assign add_sum   = {1'b0, cur} + {1'b0, cmd_delay};
  assign add_due   = add_sum[TIME_BITS] ? TMAX : add_sum[TIME_BITS-1:0];
  assign fire_hit  = have && (bdue <= limit);
  assign is_last   = (rptr == (wptr - CW'(1)));

  // pass comparisons on the entry coming out of memory
  assign better   = pend && valid[pslot] &&
                    (!have || (eq.due < bdue) || ((eq.due == bdue) && (eq.ident < bid)));
  assign tick_hit = pend && valid[pslot] && eq.kind;
  assign rm_hit   = pend && !found && valid[pslot] && (eq.ident == target);

  // lowest free slot
  always_comb begin
    free_hit  = 1'b0;
    free_slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_hit  = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tqm_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (cmd.func == tqm_pkg::FN_REMOVE) ? tqm_pkg::S_REMOVE : tqm_pkg::S_MIN;
        end
      end
      tqm_pkg::S_REMOVE: begin
        if (scan_done) state_next = tqm_pkg::S_MIN;
      end
      tqm_pkg::S_MIN: begin
        if (scan_done) state_next = fire_en ? tqm_pkg::S_FIRE : tqm_pkg::S_DUE;
      end
      tqm_pkg::S_FIRE: begin
        priority if (fire_hit) state_next = tqm_pkg::S_MIN;
        else if (fwd)          state_next = tqm_pkg::S_TICK;
        else                   state_next = tqm_pkg::S_DUE;
      end
      tqm_pkg::S_TICK: begin
        if (scan_done) state_next = tqm_pkg::S_DUE;
      end
      tqm_pkg::S_DUE:    state_next = tqm_pkg::S_OUT_RD;
      tqm_pkg::S_OUT_RD: state_next = tqm_pkg::S_OUT_SHOW;
      tqm_pkg::S_OUT_SHOW: begin
        if (!rsp_stall) state_next = is_last ? tqm_pkg::S_IDLE : tqm_pkg::S_OUT_RD;
      end
      default: state_next = tqm_pkg::S_IDLE;
    endcase
  end

  assign start_scan = (state_next != state) &&
                      ((state_next == tqm_pkg::S_REMOVE) || (state_next == tqm_pkg::S_MIN) ||
                       (state_next == tqm_pkg::S_TICK));

  // outputs and memory write ports
  always_comb begin
    cmd_stall = (state != tqm_pkg::S_IDLE);
    rsp_valid = (state == tqm_pkg::S_OUT_SHOW);
    rb_we     = 1'b0;
    rb_waddr  = (state == tqm_pkg::S_IDLE) ? '0 : wptr[SW-1:0];
    rb_wdata  = '0;
    ewe       = 1'b0;
    ewaddr    = free_slot;
    ewdata.kind  = (cmd.func == tqm_pkg::FN_ADD_ANIMATOR);
    ewdata.start = cur;
    ewdata.due   = add_due;
    ewdata.ident = nid;
    unique case (state)
      tqm_pkg::S_IDLE: begin
        if (accept) begin
          rb_we = 1'b1;
          unique case (cmd.func)
            tqm_pkg::FN_ADD_TIMEOUT, tqm_pkg::FN_ADD_ANIMATOR: begin
              if (free_hit) begin
                ewe             = 1'b1;
                rb_wdata.new_id = nid;
              end else begin
                rb_wdata.status = tqm_pkg::STAT_FULL;
              end
            end
            tqm_pkg::FN_REMOVE: rb_we = 1'b0;
            tqm_pkg::FN_UPDATE: begin
              if (halted) rb_wdata.status = tqm_pkg::STAT_HALTED;
              else        rb_we = 1'b0;
            end
            default: ;
          endcase
        end
      end
      tqm_pkg::S_REMOVE: begin
        if (scan_done) begin
          rb_we           = 1'b1;
          rb_wdata.status = found ? tqm_pkg::STAT_OK : tqm_pkg::STAT_NOT_FOUND;
        end
      end
      tqm_pkg::S_FIRE: begin
        if (fire_hit) begin
          rb_we             = 1'b1;
          rb_wdata.fired_id = bid;
          if (bkind) begin
            rb_wdata.fired_kind = tqm_pkg::KIND_ANIM_DONE;
            rb_wdata.elapsed    = 32'(bdue - bstart);
          end else begin
            rb_wdata.fired_kind = tqm_pkg::KIND_TIMEOUT;
          end
        end
      end
      tqm_pkg::S_TICK: begin
        if (tick_hit) begin
          rb_we               = 1'b1;
          rb_wdata.fired_id   = eq.ident;
          rb_wdata.fired_kind = tqm_pkg::KIND_ANIM_TICK;
          rb_wdata.elapsed    = 32'(cur - eq.start);
        end
      end
      tqm_pkg::S_DUE: begin
        // an update that produced nothing still answers once
        rb_we = (wptr == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.status     = rb_q.status;
    rsp.new_id     = rb_q.new_id;
    rsp.fired_id   = rb_q.fired_id;
    rsp.fired_kind = rb_q.fired_kind;
    rsp.elapsed    = rb_q.elapsed;
    rsp.next_due   = nd;
    rsp.last       = is_last;
  end

  // entry memory, one read per cycle at the scan index
  always_ff @(posedge clk) begin
    if (ewe) begin
      emem[ewaddr] <= ewdata;
    end
    eq <= emem[idx];
  end

  tqm_result_buf #(
    .DEPTH (TABLE_DEPTH),
    .AW    (SW)
  ) u_rbuf (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (rb_wdata),
    .raddr (rptr[SW-1:0]),
    .rdata (rb_q)
  );

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tqm_pkg::S_IDLE;
      valid   <= '0;
      cur     <= '0;
      nid     <= '0;
      anim    <= '0;
      halted  <= 1'b0;
      issuing <= 1'b0;
      pend    <= 1'b0;
    end else begin
      state <= state_next;

      // scan sequencer: address out, data back in the following cycle
      if (start_scan) begin
        idx     <= '0;
        issuing <= 1'b1;
        pend    <= 1'b0;
        // the tick pass keeps the earliest entry of the last search for next_due
        if (state_next != tqm_pkg::S_TICK) have <= 1'b0;
      end else if (scanning) begin
        pend  <= issuing;
        pslot <= idx;
        if (issuing) begin
          if (idx == SW'(TABLE_DEPTH - 1)) issuing <= 1'b0;
          else                             idx     <= idx + SW'(1);
        end
      end

      if (rb_we) begin
        wptr <= (state == tqm_pkg::S_IDLE) ? CW'(1) : wptr + CW'(1);
      end else if (state == tqm_pkg::S_IDLE) begin
        wptr <= '0;
      end

      unique case (state)
        tqm_pkg::S_IDLE: begin
          if (accept) begin
            fire_en <= 1'b0;
            fwd     <= 1'b0;
            target  <= cmd.target_id;
            found   <= 1'b0;
            newt    <= cmd_newt;
            unique case (cmd.func)
              tqm_pkg::FN_ADD_TIMEOUT, tqm_pkg::FN_ADD_ANIMATOR: begin
                if (free_hit) begin
                  valid[free_slot] <= 1'b1;
                  nid              <= nid + 16'd1;
                  if (cmd.func == tqm_pkg::FN_ADD_ANIMATOR) anim <= anim + CW'(1);
                end
              end
              tqm_pkg::FN_UPDATE: begin
                if (!halted) begin
                  fire_en <= 1'b1;
                  fwd     <= (cmd_newt > cur);
                  limit   <= (cmd_newt > cur) ? cmd_newt : cur;
                end
              end
              tqm_pkg::FN_TERMINATE: begin
                halted <= 1'b1;
                valid  <= '0;
                anim   <= '0;
              end
              default: ;
            endcase
          end
        end
        tqm_pkg::S_REMOVE: begin
          if (rm_hit) begin
            found        <= 1'b1;
            valid[pslot] <= 1'b0;
            if (eq.kind && (anim != '0)) anim <= anim - CW'(1);
          end
        end
        tqm_pkg::S_MIN: begin
          if (better) begin
            have   <= 1'b1;
            bslot  <= pslot;
            bdue   <= eq.due;
            bid    <= eq.ident;
            bkind  <= eq.kind;
            bstart <= eq.start;
          end
        end
        tqm_pkg::S_FIRE: begin
          if (fire_hit) begin
            valid[bslot] <= 1'b0;
            cur          <= bdue;
            if (bkind && (anim != '0)) anim <= anim - CW'(1);
          end else if (fwd) begin
            cur <= newt;
          end
        end
        tqm_pkg::S_DUE: begin
          rptr <= '0;
          priority if (anim != '0) nd <= 32'((cur == TMAX) ? TMAX : cur + TIME_BITS'(1));
          else if (have)           nd <= 32'(bdue);
          else                     nd <= 32'(TMAX);
        end
        tqm_pkg::S_OUT_SHOW: begin
          if (!rsp_stall && !is_last) rptr <= rptr + CW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

/* design/tqm_result_buf.sv */
// result buffer: holds the beats of one command until next_due is known
module tqm_result_buf #(
  parameter int DEPTH = tqm_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  tqm_pkg::rec_t wdata,
  input  logic [AW-1:0] raddr,
  output tqm_pkg::rec_t rdata
);

  tqm_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/tqm_checker.sv */
// port-level checks of the timeout queue manager, bound to the top level
module tqm_checker (
  input logic          clk,
  input logic          rst,
  input tqm_pkg::cmd_t cmd,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input tqm_pkg::rsp_t rsp,
  input logic          rsp_valid,
  input logic          rsp_stall
);

  // no new command while beats of the current one are going out
  a_busy_while_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> cmd_stall)
    else $error("command taken while responding");

  // an accepted command always keeps the block busy the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("block not busy after command");

  // a stalled beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled beat changed");

  // nothing follows the final beat of a command
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && rsp.last) |=> !rsp_valid)
    else $error("beat after last");

endmodule

bind timeout_queue_manager tqm_checker u_tqm_checker (.*);

/* dv/testbench.sv */
// self-checking testbench of the timeout queue manager
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  tqm_pkg::cmd_t cmd = '0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  tqm_pkg::rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall = 1'b0;

  timeout_queue_manager dut (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow copy of the timer table
  logic        tbl_valid [DEPTH];
  logic        tbl_anim  [DEPTH];
  logic [31:0] tbl_start [DEPTH];
  logic [31:0] tbl_end   [DEPTH];
  logic [15:0] tbl_id    [DEPTH];
  logic [31:0] clock_now;
  logic [15:0] id_next;
  int          anim_count;
  logic        is_halted;

  tqm_pkg::rsp_t pending_rsp[$];
  int   error_count = 0;
  int   beat_count = 0;
  int   fire_count = 0;
  int   tick_count = 0;
  int   full_count = 0;
  logic long_hold = 1'b0;

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_valid[i]) begin
        if (best < 0 || tbl_end[i] < tbl_end[best] ||
            (tbl_end[i] == tbl_end[best] && tbl_id[i] < tbl_id[best])) best = i;
      end
    end
    return best;
  endfunction

  function automatic int count_live();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) if (tbl_valid[i]) n++;
    return n;
  endfunction

  function automatic tqm_pkg::rsp_t beat_of(tqm_pkg::status_e st, logic [15:0] nid,
                                            logic [15:0] fid, tqm_pkg::kind_e kd,
                                            logic [31:0] el);
    tqm_pkg::rsp_t r;
    r = '0;
    r.status = st;
    r.new_id = nid;
    r.fired_id = fid;
    r.fired_kind = kd;
    r.elapsed = el;
    return r;
  endfunction

  // fire everything with end at or below the limit, earliest first
  task automatic fire_expired(logic [31:0] limit, ref tqm_pkg::rsp_t outq[$]);
    int s;
    forever begin
      s = earliest_slot();
      if (s < 0 || tbl_end[s] > limit) return;
      tbl_valid[s] = 1'b0;
      clock_now = tbl_end[s];
      if (tbl_anim[s]) begin
        outq.push_back(beat_of(tqm_pkg::STAT_OK, '0, tbl_id[s], tqm_pkg::KIND_ANIM_DONE,
                               tbl_end[s] - tbl_start[s]));
        if (anim_count > 0) anim_count--;
      end else begin
        outq.push_back(beat_of(tqm_pkg::STAT_OK, '0, tbl_id[s], tqm_pkg::KIND_TIMEOUT, '0));
      end
    end
  endtask

  // predicts the result beats of one command and updates the shadow state
  task automatic predict_command(tqm_pkg::cmd_t c);
    tqm_pkg::rsp_t outq[$];
    int slot;
    logic [32:0] sum;
    logic [31:0] due;
    slot = -1;
    case (c.func)
      tqm_pkg::FN_ADD_TIMEOUT, tqm_pkg::FN_ADD_ANIMATOR: begin
        for (int i = 0; i < DEPTH; i++) if (!tbl_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          outq.push_back(beat_of(tqm_pkg::STAT_FULL, '0, '0, tqm_pkg::KIND_NONE, '0));
        end else begin
          sum = {1'b0, clock_now} + {1'b0, c.delay};
          tbl_valid[slot] = 1'b1;
          tbl_anim[slot] = (c.func == tqm_pkg::FN_ADD_ANIMATOR);
          tbl_start[slot] = clock_now;
          tbl_end[slot] = sum[32] ? ALL_ONES : sum[31:0];
          tbl_id[slot] = id_next;
          if (c.func == tqm_pkg::FN_ADD_ANIMATOR) anim_count++;
          outq.push_back(beat_of(tqm_pkg::STAT_OK, id_next, '0, tqm_pkg::KIND_NONE, '0));
          id_next++;
        end
      end
      tqm_pkg::FN_REMOVE: begin
        for (int i = 0; i < DEPTH; i++)
          if (tbl_valid[i] && tbl_id[i] == c.target_id && slot < 0) slot = i;
        if (slot < 0) begin
          outq.push_back(beat_of(tqm_pkg::STAT_NOT_FOUND, '0, '0, tqm_pkg::KIND_NONE, '0));
        end else begin
          tbl_valid[slot] = 1'b0;
          if (tbl_anim[slot] && anim_count > 0) anim_count--;
          outq.push_back(beat_of(tqm_pkg::STAT_OK, '0, '0, tqm_pkg::KIND_NONE, '0));
        end
      end
      tqm_pkg::FN_UPDATE: begin
        if (is_halted) begin
          outq.push_back(beat_of(tqm_pkg::STAT_HALTED, '0, '0, tqm_pkg::KIND_NONE, '0));
        end else if (c.new_time <= clock_now) begin
          fire_expired(clock_now, outq);
        end else begin
          fire_expired(c.new_time, outq);
          clock_now = c.new_time;
          for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_anim[i])
              outq.push_back(beat_of(tqm_pkg::STAT_OK, '0, tbl_id[i],
                                     tqm_pkg::KIND_ANIM_TICK, clock_now - tbl_start[i]));
        end
        if (outq.size() == 0)
          outq.push_back(beat_of(tqm_pkg::STAT_OK, '0, '0, tqm_pkg::KIND_NONE, '0));
      end
      tqm_pkg::FN_TERMINATE: begin
        is_halted = 1'b1;
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
        anim_count = 0;
        outq.push_back(beat_of(tqm_pkg::STAT_OK, '0, '0, tqm_pkg::KIND_NONE, '0));
      end
      default: outq.push_back(beat_of(tqm_pkg::STAT_OK, '0, '0, tqm_pkg::KIND_NONE, '0));
    endcase
    // next_due is taken after the whole command
    if (anim_count > 0) begin
      due = (clock_now == ALL_ONES) ? ALL_ONES : clock_now + 32'd1;
    end else begin
      slot = earliest_slot();
      due = (slot >= 0) ? tbl_end[slot] : ALL_ONES;
    end
    foreach (outq[i]) begin
      outq[i].next_due = due;
      outq[i].last = (i == outq.size() - 1);
      pending_rsp.push_back(outq[i]);
    end
  endtask

  // one command beat, with a random gap before it unless no_gap is set
  task automatic send_command(logic [2:0] fn, logic [31:0] dl, logic [15:0] tid,
                              logic [31:0] nt, bit no_gap = 0);
    tqm_pkg::cmd_t c;
    int gap;
    c.func = fn;
    c.delay = dl;
    c.target_id = tid;
    c.new_time = nt;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_command(c);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // receiver stall: random per beat, or a long hold-off when asked
  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        rsp_stall <= 1'b1;
        repeat (300) @(negedge clk);
        rsp_stall <= 1'b0;
        long_hold = 1'b0;
      end else begin
        w = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
          rsp_stall <= 1'b1;
          repeat (w - 1) @(negedge clk);
          @(negedge clk);
        end
        rsp_stall <= 1'b0;
        @(posedge clk);
        while (!rsp_valid) @(posedge clk);
      end
    end
  end

  // result checker, compares each accepted beat with the oldest prediction
  initial begin
    tqm_pkg::rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        beat_count++;
        if (pending_rsp.size() == 0) begin
          error_count++;
          $display("%0t: unexpected beat, expected none, actual %h", $time, rsp);
        end else begin
          want = pending_rsp.pop_front();
          if (want.fired_kind == tqm_pkg::KIND_TIMEOUT ||
              want.fired_kind == tqm_pkg::KIND_ANIM_DONE)
            fire_count++;
          if (want.fired_kind == tqm_pkg::KIND_ANIM_TICK) tick_count++;
          if (want.status == tqm_pkg::STAT_FULL) full_count++;
          if (rsp.status !== want.status) begin
            error_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
          end
          if (rsp.new_id !== want.new_id) begin
            error_count++;
            $display("%0t: new_id expected %0d actual %0d", $time, want.new_id, rsp.new_id);
          end
          if (rsp.fired_id !== want.fired_id) begin
            error_count++;
            $display("%0t: fired_id expected %0d actual %0d", $time, want.fired_id,
                     rsp.fired_id);
          end
          if (rsp.fired_kind !== want.fired_kind) begin
            error_count++;
            $display("%0t: fired_kind expected %0d actual %0d", $time, want.fired_kind,
                     rsp.fired_kind);
          end
          if (rsp.elapsed !== want.elapsed) begin
            error_count++;
            $display("%0t: elapsed expected %h actual %h", $time, want.elapsed, rsp.elapsed);
          end
          if (rsp.next_due !== want.next_due) begin
            error_count++;
            $display("%0t: next_due expected %h actual %h", $time, want.next_due,
                     rsp.next_due);
          end
          if (rsp.last !== want.last) begin
            error_count++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, rsp.last);
          end
        end
      end
    end
  end

  // directed: extremes, every command, full table, saturation of far delays
  task automatic test_directed();
    send_command(tqm_pkg::FN_UPDATE, 0, 0, 0);                 // empty update
    send_command(tqm_pkg::FN_REMOVE, 0, 16'hFFFF, 0);          // missing id
    send_command(tqm_pkg::FN_ADD_TIMEOUT, 0, 0, 0);            // due now
    send_command(tqm_pkg::FN_ADD_ANIMATOR, 32'd50, 0, 0);
    send_command(tqm_pkg::FN_ADD_TIMEOUT, ALL_ONES, 16'hFFFF, ALL_ONES);  // far delay
    send_command(tqm_pkg::FN_UPDATE, 0, 0, 0);                 // equal update fires due only
    send_command(tqm_pkg::FN_UPDATE, 0, 0, 32'd20);            // tick
    send_command(tqm_pkg::FN_UPDATE, 0, 0, 32'd10);            // backward
    send_command(tqm_pkg::FN_UPDATE, 0, 0, 32'd100);           // animator expires
    send_command(3'd5, ALL_ONES, 16'hFFFF, ALL_ONES);          // unused codes
    send_command(3'd6, 0, 0, 0);
    send_command(3'd7, 0, 0, 0);
    for (int i = 0; i < DEPTH + 1; i++)
      send_command(i[0] ? tqm_pkg::FN_ADD_ANIMATOR : tqm_pkg::FN_ADD_TIMEOUT,
                   32'd1000 + 32'(i), 0, 0, 1);
    send_command(tqm_pkg::FN_REMOVE, 0, 16'd5, 0);
    send_command(tqm_pkg::FN_UPDATE, 0, 0, ALL_ONES);          // clock at maximum
    wait_drained();
  endtask

  // long receiver hold-off while commands keep coming
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++)
      send_command(($urandom_range(0, 2) == 0) ? tqm_pkg::FN_UPDATE : tqm_pkg::FN_ADD_ANIMATOR,
                   32'($urandom_range(1, 200)), 0,
                   clock_now + 32'($urandom_range(0, 100)), 1);
    wait_drained();
  endtask

  // random mix, mostly adds and forward updates so entries fire and tick
  task automatic test_random(int n);
    int pick;
    logic [31:0] dl, nt;
    logic [15:0] tid;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      dl = ($urandom_range(0, 19) == 0) ? $urandom() : 32'($urandom_range(0, 300));
      nt = ($urandom_range(0, 9) == 0) ? $urandom()
           : clock_now + 32'($urandom_range(0, 150))
             - (($urandom_range(0, 5) == 0) ? 32'd60 : 32'd0);
      tid = ($urandom_range(0, 9) == 0) ? 16'($urandom())
            : id_next - 16'($urandom_range(1, 20));
      if (count_live() >= DEPTH - 2 && pick < 50) pick = 70;
      if (pick < 28) send_command(tqm_pkg::FN_ADD_TIMEOUT, dl, tid, nt);
      else if (pick < 50) send_command(tqm_pkg::FN_ADD_ANIMATOR, dl, tid, nt);
      else if (pick < 62) send_command(tqm_pkg::FN_REMOVE, dl, tid, nt);
      else if (pick < 97) send_command(tqm_pkg::FN_UPDATE, dl, tid, nt);
      else if (pick < 98) send_command(3'($urandom_range(5, 7)), dl, tid, nt);
      else send_command(tqm_pkg::FN_UPDATE, dl, tid,
                        32'hFFFF_FFF0 + 32'($urandom_range(0, 15)));
      if (i % 97 == 96) wait_drained();  // sender pause until all results are in
    end
    wait_drained();
  endtask

  // termination: updates refused, adds still taken
  task automatic test_terminate();
    send_command(tqm_pkg::FN_ADD_ANIMATOR, 32'd5, 0, 0);
    send_command(tqm_pkg::FN_TERMINATE, 0, 0, 0);
    send_command(tqm_pkg::FN_UPDATE, 0, 0, clock_now + 32'd50);
    send_command(tqm_pkg::FN_ADD_TIMEOUT, 32'd3, 0, 0);
    send_command(tqm_pkg::FN_REMOVE, 0, id_next - 16'd1, 0);
    for (int i = 0; i < 20; i++)
      send_command(3'($urandom_range(0, 4)), $urandom(), 16'($urandom()), $urandom());
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    clock_now = '0;
    id_next = '0;
    anim_count = 0;
    is_halted = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(400);
    test_terminate();
    $display("covered %0d beats: %0d expiries, %0d animator ticks, %0d full-table adds",
             beat_count, fire_count, tick_count, full_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run-time limit
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
